@@ rtl/hpq_pkg.sv @@
// Shared types and codes for the max-heap priority queue.
// No dependencies; used by hpq_cmp, max_heap_priority_queue_top and the testbench.
`default_nettype none

package hpq_pkg;

  localparam int unsigned FIELD_W = 16;
  localparam int unsigned ENTRY_W = 3 * FIELD_W;

  // request codes
  localparam logic REQ_INSERT = 1'b0;
  localparam logic REQ_REMOVE = 1'b1;

  typedef struct packed {
    logic [FIELD_W-1:0] prio;
    logic [FIELD_W-1:0] job;
    logic [FIELD_W-1:0] pages;
  } entry_t;

  // verdict of the shared comparator
  typedef struct packed {
    logic move;        // a child beats the node
    logic pick_right;  // the winner is the right child
  } cmp_res_t;

endpackage

`default_nettype wire

@@ rtl/hpq_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none

module hpq_ram #(
  parameter int unsigned WIDTH = 48,
  parameter int unsigned DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

@@ rtl/hpq_cmp.sv @@
// Shared priority comparator: picks the winner of a node and up to two children.
// Depends on hpq_pkg. Used for both sift directions (sift-up feeds the
// moving entry as the only child and its parent as the node).
`default_nettype none

module hpq_cmp (
  input  wire hpq_pkg::entry_t  node,
  input  wire hpq_pkg::entry_t  left,
  input  wire hpq_pkg::entry_t  right,
  input  wire logic             right_ok,
  output hpq_pkg::cmp_res_t     res
);

  logic [hpq_pkg::FIELD_W-1:0] best_prio;
  logic                        left_wins;

  always_comb begin
    // left on ties; right only when strictly above the best so far
    left_wins = left.prio > node.prio;
    best_prio = left_wins ? left.prio : node.prio;
    res.pick_right = right_ok && (right.prio > best_prio);
    res.move = left_wins || res.pick_right;
  end

endmodule

`default_nettype wire

@@ rtl/max_heap_priority_queue_top.sv @@
// Binary max-heap priority queue: sequencer, heap RAM and shared comparator.
// Depends on hpq_pkg, hpq_ram and hpq_cmp.
//
// Usage: drive req_type and the new_* fields with start high while busy is
// low; the request is taken at that clock edge. An insert (req_type 0) adds
// the entry; a remove (req_type 1) drops the highest-priority entry. An insert
// on a full queue or a remove on an empty one changes nothing and reports
// accepted = 0. Each request gives one result: done is high for exactly one
// cycle with accepted, top_valid, top_* (root entry, zero when empty) and
// entry_count. The receiver cannot hold results off; busy stays high until
// the result cycle, in which a new request may already be started.
// Requests take longer the further the entry climbs or sinks: a rejected
// request or a remove down to empty is answered from idle, an insert into an
// empty queue writes the root directly, and otherwise the entry climbs to its
// parent or sinks to a child level by level until a compare stops it or it
// reaches the root or a leaf. The pace is set by the single RAM read port:
// sift-up reads one parent per cycle, sift-down reads two children per level.
// Reset (rst, synchronous) empties the queue; the RAM contents need no
// clearing since a slot is only used after an entry has been written to it.
`default_nettype none

module max_heap_priority_queue_top #(
  parameter int unsigned CAPACITY = 16
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  output logic             busy,
  input  wire logic        req_type,
  input  wire logic [15:0] new_priority,
  input  wire logic [15:0] new_job,
  input  wire logic [15:0] new_pages,
  output logic             done,
  output logic             accepted,
  output logic             top_valid,
  output logic [15:0]      top_priority,
  output logic [15:0]      top_job,
  output logic [15:0]      top_pages,
  output logic [4:0]       entry_count
);

  localparam int unsigned AW = $clog2(CAPACITY);
  localparam int unsigned CW = $clog2(CAPACITY + 1);
  localparam int unsigned IW = AW + 2;

  typedef enum logic [7:0] {
    IDLE    = 8'b0000_0001,
    UP_RD   = 8'b0000_0010,
    UP_CMP  = 8'b0000_0100,
    DN_LAST = 8'b0000_1000,
    DN_GETL = 8'b0001_0000,
    DN_GETR = 8'b0010_0000,
    DN_CMP  = 8'b0100_0000,
    WR      = 8'b1000_0000
  } state_t;

  state_t            state, state_next;
  logic [AW-1:0]     pos, pos_next;
  logic [CW-1:0]     count, count_next;
  hpq_pkg::entry_t   cur, cur_next;
  hpq_pkg::entry_t   lch, lch_next;
  hpq_pkg::entry_t   top;
  logic              accepted_next, done_next;

  logic              we;
  logic [AW-1:0]     waddr, raddr;
  hpq_pkg::entry_t   wdata, rdata;

  hpq_pkg::entry_t   cmp_node, cmp_left, cmp_right;
  logic              cmp_right_ok;
  hpq_pkg::cmp_res_t cmp_res;

  logic [IW-1:0]     count_ix;
  logic [AW-1:0]     par, child;
  logic [IW-1:0]     child_ix;
  logic [CW+4:0]     count_wide;

  function automatic logic [AW-1:0] parent_of(input logic [AW-1:0] p);
    logic [AW-1:0] m;
    m = p - AW'(1);
    return m >> 1;
  endfunction

  function automatic logic [IW-1:0] left_of(input logic [AW-1:0] p);
    return {1'b0, p, 1'b1};
  endfunction

  function automatic logic [IW-1:0] right_of(input logic [AW-1:0] p);
    return {1'b0, p, 1'b0} + IW'(2);
  endfunction

  hpq_ram #(
    .WIDTH (hpq_pkg::ENTRY_W),
    .DEPTH (CAPACITY)
  ) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

  hpq_cmp u_cmp (
    .node     (cmp_node),
    .left     (cmp_left),
    .right    (cmp_right),
    .right_ok (cmp_right_ok),
    .res      (cmp_res)
  );

  assign count_ix = IW'(count);
  assign par      = parent_of(pos);

  // comparator operands per sift direction
  always_comb begin
    if (state == UP_CMP) begin
      cmp_node     = rdata;
      cmp_left     = cur;
      cmp_right    = rdata;
      cmp_right_ok = 1'b0;
    end else begin
      cmp_node     = cur;
      cmp_left     = lch;
      cmp_right    = rdata;
      cmp_right_ok = right_of(pos) < count_ix;
    end
  end

  assign child_ix = cmp_res.pick_right ? right_of(pos) : left_of(pos);
  assign child    = child_ix[AW-1:0];

  always_comb begin
    state_next    = state;
    pos_next      = pos;
    count_next    = count;
    cur_next      = cur;
    lch_next      = lch;
    accepted_next = accepted;
    done_next     = 1'b0;
    we            = 1'b0;
    waddr         = pos;
    wdata         = cur;
    raddr         = '0;
    unique case (state)
      IDLE: begin
        if (start) begin
          if (req_type == hpq_pkg::REQ_INSERT) begin
            if (count < CW'(CAPACITY)) begin
              cur_next      = '{prio: new_priority, job: new_job, pages: new_pages};
              pos_next      = count[AW-1:0];
              count_next    = count + CW'(1);
              accepted_next = 1'b1;
              state_next    = (count == '0) ? WR : UP_RD;
            end else begin
              accepted_next = 1'b0;
              done_next     = 1'b1;
            end
          end else begin
            if (count != '0) begin
              count_next    = count - CW'(1);
              pos_next      = '0;
              accepted_next = 1'b1;
              if (count == CW'(1)) begin
                done_next = 1'b1;
              end else begin
                state_next = DN_LAST;
              end
            end else begin
              accepted_next = 1'b0;
              done_next     = 1'b1;
            end
          end
        end
      end
      UP_RD: begin
        raddr      = par;
        state_next = UP_CMP;
      end
      UP_CMP: begin
        // one level per cycle: move the parent down and fetch the next one
        if (cmp_res.move) begin
          we       = 1'b1;
          wdata    = rdata;
          pos_next = par;
          raddr    = parent_of(par);
          if (par == '0) begin
            state_next = WR;
          end
        end else begin
          state_next = WR;
        end
      end
      DN_LAST: begin
        raddr      = count[AW-1:0];
        state_next = DN_GETL;
      end
      DN_GETL: begin
        cur_next = rdata;
        if (left_of(pos) < count_ix) begin
          raddr      = AW'(left_of(pos));
          state_next = DN_GETR;
        end else begin
          state_next = WR;
        end
      end
      DN_GETR: begin
        lch_next = rdata;
        if (right_of(pos) < count_ix) begin
          raddr = AW'(right_of(pos));
        end
        state_next = DN_CMP;
      end
      DN_CMP: begin
        if (cmp_res.move) begin
          we       = 1'b1;
          wdata    = cmp_res.pick_right ? rdata : lch;
          pos_next = child;
          if (left_of(child) < count_ix) begin
            raddr      = AW'(left_of(child));
            state_next = DN_GETR;
          end else begin
            state_next = WR;
          end
        end else begin
          state_next = WR;
        end
      end
      WR: begin
        we         = 1'b1;
        done_next  = 1'b1;
        state_next = IDLE;
      end
      default: begin
        state_next = IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= IDLE;
      count    <= '0;
      done     <= 1'b0;
      accepted <= 1'b0;
    end else begin
      state    <= state_next;
      count    <= count_next;
      done     <= done_next;
      accepted <= accepted_next;
    end
  end

  // payload registers; top shadows slot 0 of the RAM
  always_ff @(posedge clk) begin
    pos <= pos_next;
    cur <= cur_next;
    lch <= lch_next;
    if (we && waddr == '0) begin
      top <= wdata;
    end
  end

  assign busy         = state != IDLE;
  assign top_valid    = count != '0;
  assign top_priority = top_valid ? top.prio  : '0;
  assign top_job      = top_valid ? top.job   : '0;
  assign top_pages    = top_valid ? top.pages : '0;
  assign count_wide   = {5'b0, count};
  assign entry_count  = count_wide[4:0];

  a_done_idle : assert property (@(posedge clk) disable iff (rst)
    done |-> !busy)
    else $error("result strobe while sequencer still working");

  a_count_max : assert property (@(posedge clk) disable iff (rst)
    count <= CW'(CAPACITY))
    else $error("entry count above capacity");

  a_full_reject : assert property (@(posedge clk) disable iff (rst)
    (start && !busy && req_type == hpq_pkg::REQ_INSERT && count == CW'(CAPACITY))
      |=> done && !accepted && $stable(count))
    else $error("insert on full queue not rejected");

  a_empty_reject : assert property (@(posedge clk) disable iff (rst)
    (start && !busy && req_type == hpq_pkg::REQ_REMOVE && count == '0)
      |=> done && !accepted && !top_valid)
    else $error("remove on empty queue not rejected");

endmodule

`default_nettype wire

@@ verif/tb_max_heap_priority_queue_top.sv @@
`timescale 1ns / 1ps
// Self-checking testbench for max_heap_priority_queue_top: directed and random
// insert/remove traffic scored against a behavioural heap. Needs hpq_pkg and the RTL.

module tb_max_heap_priority_queue_top;

  localparam int unsigned CAPACITY     = 16;
  localparam int unsigned QUIET_LIMIT  = 400;
  localparam int unsigned SETTLE_TICKS = 16;
  localparam int unsigned MAX_GAP      = 24;
  localparam int unsigned SEG_LEN      = 25;
  localparam int unsigned PHASE_ITEMS  = 150;

  typedef struct packed {
    logic        accepted;
    logic        top_valid;
    logic [15:0] top_priority;
    logic [15:0] top_job;
    logic [15:0] top_pages;
    logic [4:0]  entry_count;
  } heap_status_t;

  class heap_scoreboard;
    hpq_pkg::entry_t slots [CAPACITY];
    int unsigned     fill;
    heap_status_t    status_q [$];
    int unsigned     errors;

    function new();
      fill   = 0;
      errors = 0;
    endfunction

    function void swap_slots(int unsigned a, int unsigned b);
      hpq_pkg::entry_t t;
      t        = slots[a];
      slots[a] = slots[b];
      slots[b] = t;
    endfunction

    function void climb(int unsigned pos);
      int unsigned parent;
      bit          going;
      going = 1'b1;
      while (going && pos > 0) begin
        parent = (pos - 1) / 2;
        if (slots[pos].prio <= slots[parent].prio) begin
          going = 1'b0;
        end else begin
          swap_slots(pos, parent);
          pos = parent;
        end
      end
    endfunction

    // larger child wins, left on a tie; only a strictly greater child moves up
    function void sink_root();
      int unsigned pos;
      int unsigned left;
      int unsigned best;
      logic [15:0] best_prio;
      bit          going;
      pos   = 0;
      going = 1'b1;
      while (going) begin
        left      = 2 * pos + 1;
        best      = pos;
        best_prio = slots[pos].prio;
        if (left >= fill) begin
          going = 1'b0;
        end else begin
          if (slots[left].prio > best_prio) begin
            best      = left;
            best_prio = slots[left].prio;
          end
          if (left + 1 < fill && slots[left + 1].prio > best_prio) best = left + 1;
          if (best == pos) begin
            going = 1'b0;
          end else begin
            swap_slots(pos, best);
            pos = best;
          end
        end
      end
    endfunction

    function void note_request(logic kind, hpq_pkg::entry_t item);
      heap_status_t st;
      st = '0;
      if (kind == hpq_pkg::REQ_INSERT) begin
        if (fill < CAPACITY) begin
          slots[fill] = item;
          climb(fill);
          fill++;
          st.accepted = 1'b1;
        end
      end else if (fill > 0) begin
        fill--;
        if (fill > 0) begin
          slots[0] = slots[fill];
          sink_root();
        end
        st.accepted = 1'b1;
      end
      if (fill > 0) begin
        st.top_valid    = 1'b1;
        st.top_priority = slots[0].prio;
        st.top_job      = slots[0].job;
        st.top_pages    = slots[0].pages;
      end
      st.entry_count = 5'(fill);
      status_q.push_back(st);
    endfunction

    function void compare_field(string name, logic [15:0] want, logic [15:0] got);
      if (want !== got) begin
        $display("%0t: %s mismatch: expected %0h actual %0h", $time, name, want, got);
        errors++;
      end
    endfunction

    function void check_result(heap_status_t got);
      heap_status_t want;
      if (status_q.size() == 0) begin
        $display("%0t: result with nothing outstanding: expected none actual %h", $time, got);
        errors++;
        return;
      end
      want = status_q.pop_front();
      compare_field("accepted", 16'(want.accepted), 16'(got.accepted));
      compare_field("top_valid", 16'(want.top_valid), 16'(got.top_valid));
      compare_field("top_priority", want.top_priority, got.top_priority);
      compare_field("top_job", want.top_job, got.top_job);
      compare_field("top_pages", want.top_pages, got.top_pages);
      compare_field("entry_count", 16'(want.entry_count), 16'(got.entry_count));
    endfunction

    function int unsigned pending();
      return status_q.size();
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        start = 1'b0;
  logic        req_type = hpq_pkg::REQ_INSERT;
  logic [15:0] new_priority = '0;
  logic [15:0] new_job = '0;
  logic [15:0] new_pages = '0;
  logic        busy;
  logic        done;
  logic        accepted;
  logic        top_valid;
  logic [15:0] top_priority;
  logic [15:0] top_job;
  logic [15:0] top_pages;
  logic [4:0]  entry_count;

  heap_scoreboard sb;
  int unsigned    quiet_ticks;

  max_heap_priority_queue_top #(.CAPACITY(CAPACITY)) i_dut (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .req_type     (req_type),
    .new_priority (new_priority),
    .new_job      (new_job),
    .new_pages    (new_pages),
    .done         (done),
    .accepted     (accepted),
    .top_valid    (top_valid),
    .top_priority (top_priority),
    .top_job      (top_job),
    .top_pages    (top_pages),
    .entry_count  (entry_count)
  );

  always #2 clk = ~clk;

  // results cannot be held off: every done cycle is a transfer
  always @(posedge clk) begin : result_monitor
    heap_status_t got;
    if (!rst && done) begin
      got.accepted     = accepted;
      got.top_valid    = top_valid;
      got.top_priority = top_priority;
      got.top_job      = top_job;
      got.top_pages    = top_pages;
      got.entry_count  = entry_count;
      sb.check_result(got);
    end
  end

  always @(posedge clk) begin
    if (rst || (start && !busy) || done) begin
      quiet_ticks <= 0;
    end else if (quiet_ticks >= QUIET_LIMIT) begin
      $display("%0t: watchdog expired with %0d results outstanding", $time, sb.pending());
      $display("tb_max_heap_priority_queue_top: FAIL");
      $finish;
    end else begin
      quiet_ticks <= quiet_ticks + 1;
    end
  end

  // returns in the step of the accepting edge, start still high
  task automatic send_request(logic kind, logic [15:0] p, logic [15:0] j, logic [15:0] g);
    hpq_pkg::entry_t item;
    item.prio  = p;
    item.job   = j;
    item.pages = g;
    start        <= 1'b1;
    req_type     <= kind;
    new_priority <= p;
    new_job      <= j;
    new_pages    <= g;
    do @(posedge clk); while (busy);
    sb.note_request(kind, item);
  endtask

  task automatic idle_gap(int unsigned pct);
    int unsigned gap;
    gap = 0;
    while (gap < MAX_GAP && $urandom_range(99) < pct) gap++;
    if (gap > 0) begin
      start        <= 1'b0;
      req_type     <= 1'($urandom);
      new_priority <= 16'($urandom);
      new_job      <= 16'($urandom);
      new_pages    <= 16'($urandom);
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic wait_drained();
    start <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
  endtask

  // mix of narrow values for ties, the two extremes and full-range values
  function automatic logic [15:0] pick_priority();
    case ($urandom_range(3))
      0:       return 16'($urandom_range(3));
      1:       return $urandom_range(1) ? 16'hFFFF : 16'h0000;
      default: return 16'($urandom);
    endcase
  endfunction

  initial begin : stimulus
    int unsigned mode;
    int unsigned insert_pct;
    int unsigned idle_pct [3];
    logic        kind;
    sb = new();
    idle_pct = '{0, 72, 8};
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: empty, extremes, ties at the root, drain to empty
    send_request(hpq_pkg::REQ_REMOVE, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    send_request(hpq_pkg::REQ_INSERT, 16'h0000, 16'h0000, 16'h0000);
    send_request(hpq_pkg::REQ_INSERT, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    send_request(hpq_pkg::REQ_INSERT, 16'hFFFF, 16'h1234, 16'h0001);
    send_request(hpq_pkg::REQ_INSERT, 16'h8000, 16'hAAAA, 16'h5555);
    send_request(hpq_pkg::REQ_INSERT, 16'h0001, 16'h5555, 16'hAAAA);
    repeat (5) send_request(hpq_pkg::REQ_REMOVE, 16'h0000, 16'h0000, 16'h0000);
    send_request(hpq_pkg::REQ_REMOVE, 16'h1111, 16'h2222, 16'h3333);
    send_request(hpq_pkg::REQ_INSERT, 16'h7FFF, 16'h0000, 16'hFFFF);
    send_request(hpq_pkg::REQ_INSERT, 16'h0005, 16'h0001, 16'h0010);
    send_request(hpq_pkg::REQ_INSERT, 16'h0005, 16'h0002, 16'h0020);
    send_request(hpq_pkg::REQ_INSERT, 16'h0005, 16'h0003, 16'h0030);
    send_request(hpq_pkg::REQ_INSERT, 16'h0005, 16'h0004, 16'h0040);
    repeat (6) send_request(hpq_pkg::REQ_REMOVE, 16'hFFFF, 16'h0000, 16'hFFFF);
    wait_drained();
    @(posedge clk);

    // random: segments that fill, drain or mix, so full and empty are both hit
    foreach (idle_pct[ph]) begin
      for (int unsigned k = 0; k < PHASE_ITEMS; k++) begin
        mode = (k / SEG_LEN) % 3;
        insert_pct = (mode == 0) ? 85 : (mode == 1) ? 15 : 50;
        kind = ($urandom_range(99) < insert_pct) ? hpq_pkg::REQ_INSERT : hpq_pkg::REQ_REMOVE;
        send_request(kind, pick_priority(), 16'($urandom), 16'($urandom));
        // stretches with no gaps inside the idling phases too
        if ((k / 10) % 4 != 3) idle_gap(idle_pct[ph]);
      end
      wait_drained();
      @(posedge clk);
    end

    wait_drained();
    repeat (SETTLE_TICKS) @(posedge clk);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("tb_max_heap_priority_queue_top: PASS");
    end else begin
      $display("tb_max_heap_priority_queue_top: FAIL");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
rtl/hpq_pkg.sv
rtl/hpq_ram.sv
rtl/hpq_cmp.sv
rtl/max_heap_priority_queue_top.sv
verif/tb_max_heap_priority_queue_top.sv
